// ===== src/tdp_pkg.sv =====
`default_nettype none

package tdp_pkg;

  // first odd divisor and its square
  localparam int unsigned FIRST_DIVISOR = 3;
  localparam int unsigned FIRST_SQUARE  = 9;
  // values up to this limit report prime
  localparam int unsigned SMALL_LIMIT   = 3;
  // step between odd divisors
  localparam int unsigned DIVISOR_STEP  = 2;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

`default_nettype wire

// ===== src/tdp_rem.sv =====
`default_nettype none

module tdp_rem #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [VALUE_WIDTH-1:0]  dividend,
  input  wire logic [VALUE_WIDTH-1:0]  divisor,
  output tdp_pkg::rem_status_t         status
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] dvd;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic [VALUE_WIDTH:0]   trial;

  // one dividend bit per cycle, restoring step
  always_comb begin
    trial = {rem, dvd[VALUE_WIDTH-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = VALUE_WIDTH'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      status <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= dividend;
        rem  <= '0;
        cnt  <= CW'(VALUE_WIDTH);
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[VALUE_WIDTH-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy        <= 1'b0;
          status.done <= 1'b1;
          status.zero <= (rem_next == '0);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/trial_division_prime_test.sv =====
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     value
// out      output     out_valid / out_ready   is_prime
//
// values up to 3 and even values go straight to S_FINISH without trying any divisor
// odd values pass through S_BOUND and S_DIVIDE once per odd divisor tried, each divide done by
// the bit-serial remainder unit; worst case about 2^(VALUE_WIDTH/2-1) divisors
// one request at a time; a new request is taken while a result waits at out
// a stalled out holds the finished flag; synchronous reset, no clearing pass
`default_nettype none

module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic [VALUE_WIDTH-1:0]  value,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic                    is_prime
);

  localparam int unsigned SW = VALUE_WIDTH + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BOUND,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] d;
  logic [SW-1:0]          sq;
  logic                   res;
  logic                   rem_start;
  tdp_pkg::rem_status_t   rem_status;

  assign in_ready = (state == S_IDLE);

  tdp_rem #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (v),
    .divisor  (d),
    .status   (rem_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rem_start <= 1'b0;
    end else begin
      rem_start <= 1'b0;
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            v     <= value;
            d     <= VALUE_WIDTH'(tdp_pkg::FIRST_DIVISOR);
            sq    <= SW'(tdp_pkg::FIRST_SQUARE);
            if (value <= VALUE_WIDTH'(tdp_pkg::SMALL_LIMIT)) begin
              res   <= 1'b1;
              state <= S_FINISH;
            end else if (!value[0]) begin
              res   <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_BOUND;
            end
          end
        end
        S_BOUND: begin
          if (sq > {2'b00, v}) begin
            res   <= 1'b1;
            state <= S_FINISH;
          end else begin
            rem_start <= 1'b1;
            state     <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (rem_status.done) begin
            if (rem_status.zero) begin
              res   <= 1'b0;
              state <= S_FINISH;
            end else begin
              // (d + 2)^2 = d^2 + 4d + 4
              d     <= d + VALUE_WIDTH'(tdp_pkg::DIVISOR_STEP);
              sq    <= sq + {d, 2'b00} + SW'(4);
              state <= S_BOUND;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            is_prime  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/tdp_checker.sv =====
`default_nettype none

module tdp_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [VALUE_WIDTH-1:0]  value,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    is_prime
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_prime))
    else $error("result changed while stalled");

  // waiting request holds
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(value))
    else $error("request changed while waiting");

  // an accepted request makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a new result appears only as the block returns to idle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while still working");

  // reset leaves the block idle with no result
  assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind trial_division_prime_test tdp_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_tdp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .value     (value),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_prime  (is_prime)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT   = 400000;
  localparam int unsigned RANDOM_PER_PHASE = 20;
  localparam int unsigned NUM_PROBES       = 22;
  localparam int unsigned NUM_PHASES       = 4;
  localparam int unsigned DRAIN_CYCLES     = 100;

  typedef struct {
    logic [31:0] value;
    bit          typed;
    bit          flag;
  } probe_t;

  typedef struct {
    logic [31:0] value;
    bit          flag;
  } verdict_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [31:0] value     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_prime;
  bit          req_flag  = 1'b0;

  verdict_t    pending_verdicts [$];
  int unsigned errors         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  int unsigned phase_send_idle  [NUM_PHASES] = '{0, 88, 0, 38};
  int unsigned phase_recv_stall [NUM_PHASES] = '{0, 0, 88, 38};

  // small values, even values, prime squares, large primes, wide bit patterns
  probe_t directed_probes [NUM_PROBES] = '{
    '{32'd0,          1'b1, 1'b1},
    '{32'd1,          1'b1, 1'b1},
    '{32'd2,          1'b1, 1'b1},
    '{32'd3,          1'b1, 1'b1},
    '{32'd4,          1'b1, 1'b0},
    '{32'hFFFF_FFFE,  1'b1, 1'b0},
    '{32'h8000_0000,  1'b1, 1'b0},
    '{32'h7FFF_FFFE,  1'b1, 1'b0},
    '{32'd5,          1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0},
    '{32'd15,         1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0},
    '{32'd49,         1'b0, 1'b0},
    '{32'd121,        1'b0, 1'b0},
    '{32'd65521,      1'b0, 1'b0},
    '{32'd65537,      1'b0, 1'b0},
    '{32'd994009,     1'b0, 1'b0},
    '{32'd16777213,   1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b0, 1'b0},
    '{32'h8000_0001,  1'b0, 1'b0},
    '{32'h5555_5555,  1'b0, 1'b0},
    '{32'hAAAA_AAAB,  1'b0, 1'b0}
  };

  trial_division_prime_test #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime)
  );

  always #5 clk = ~clk;

  function automatic bit predict_prime(input logic [31:0] v);
    logic [31:0] d;
    if (v <= tdp_pkg::SMALL_LIMIT) return 1'b1;
    if (!v[0]) return 1'b0;
    for (d = tdp_pkg::FIRST_DIVISOR; d <= v / d; d += tdp_pkg::DIVISOR_STEP) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly small values, large ones carry a small factor so they finish fast
  function automatic logic [31:0] random_candidate();
    logic [31:0] r;
    int unsigned pick;
    int unsigned p;
    r    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom_range(0, 4095);
    if (pick < 60) return $urandom_range(0, 65535);
    if (pick < 70) return $urandom_range(0, 1 << 20);
    if (pick < 85) return r & ~32'd1;
    p = (pick < 90) ? 3 : ((pick < 95) ? 5 : 7);
    return r - (r % p);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_request(input logic [31:0] v, input bit typed, input bit flag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    req_flag <= typed ? flag : predict_prime(v);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    verdict_t head;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("is_prime=%0b with no request outstanding", is_prime));
        end else begin
          head = pending_verdicts.pop_front();
          if (is_prime !== head.flag) begin
            report_mismatch($sformatf("value %0d: is_prime=%0b, expected %0b",
                                      head.value, is_prime, head.flag));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_verdicts.push_back('{value, req_flag});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("trial_division_prime_test test failed");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_probes[i]) begin
      send_request(directed_probes[i].value, directed_probes[i].typed, directed_probes[i].flag);
    end
    hold_until_drained();
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = phase_send_idle[ph];
      recv_stall_pct = phase_recv_stall[ph];
      repeat (RANDOM_PER_PHASE) send_request(random_candidate(), 1'b0, 1'b0);
      hold_until_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("trial_division_prime_test test passed");
    end else begin
      $display("trial_division_prime_test test failed");
    end
    $finish;
  end

endmodule
